### hw/rtl/gred_pkg.sv
// Shared types, constants and functions for the grayscale erode/dilate filter.
package gred_pkg;

   localparam int PIX_W   = 8;
   localparam int DIM_W   = 11;
   localparam int WIN_W   = 4;
   localparam int HW_W    = 3;
   localparam int TOT_W   = 22;
   localparam int CFG_W   = 11;
   localparam int CSR_A_W = 3;
   localparam int FDEPTH  = 16;
   localparam int PEND_W  = $clog2(FDEPTH + 1);

   typedef enum logic [CSR_A_W-1:0] {
      CSR_FRAME_WIDTH  = 3'd0,
      CSR_FRAME_HEIGHT = 3'd1,
      CSR_WINDOW_WIDTH = 3'd2,
      CSR_WINDOW_HEIGHT = 3'd3,
      CSR_TAKE_MAX     = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic item;
      logic step;
      logic vstep;
      logic out;
      logic fe;
      logic last;
   } tok_type;

   typedef struct packed {
      logic             valid;
      logic             par;
      logic [PIX_W-1:0] val;
   } tap_type;

   typedef struct packed {
      logic             fe;
      logic [PIX_W-1:0] pix;
   } out_type;

   function automatic logic [PIX_W-1:0] red_ident(input logic tmax);
      return tmax ? '0 : '1;
   endfunction

   function automatic logic [PIX_W-1:0] red2(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b,
                                             input logic tmax);
      if (tmax) begin
         return (b > a) ? b : a;
      end
      return (b < a) ? b : a;
   endfunction

   function automatic logic [HW_W-1:0] half_of(input logic [WIN_W-1:0] win, input int cap);
      logic [WIN_W-1:0] odd;
      odd = win | WIN_W'(1);
      if (int'(odd) > cap) begin
         odd = WIN_W'(cap);
      end
      return HW_W'(odd >> 1);
   endfunction

endpackage

### hw/rtl/gray_rect_erode_dilate_top.sv
// Grayscale rectangular erosion/dilation filter, streamed in raster order.
// Throughput: one transaction per clock, input and output, while neither handshake stalls.
// Results pass stages b, c, d, e and the result queue after the transaction releasing them;
// output pixel n is released by input pixel n + half_h*width + half_w, drain ticks flush.
// Reset (synchronous): registers to defaults, counters and window chain cleared;
// row stores are not cleared and need no clearing pass.
module gray_rect_erode_dilate_top #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int MAX_WINDOW = 15
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [gred_pkg::PIX_W-1:0]   req_tdata,   // pixel
   input  logic                         req_tuser,   // kind
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [gred_pkg::PIX_W-1:0]   rsp_tdata,   // out_pixel
   output logic                         rsp_tlast,
   input  logic                         csr_we,
   input  logic [gred_pkg::CSR_A_W-1:0] csr_addr,
   input  logic [gred_pkg::CFG_W-1:0]   csr_wdata
);
   import gred_pkg::*;

   localparam int NB      = MAX_WINDOW;
   localparam int ODD_CAP = ((MAX_WINDOW - 1) | 1);
   localparam int NT      = ODD_CAP;
   localparam int NG      = (NB + 3) / 4;
   localparam int NTG     = (NT + 3) / 4;
   localparam int ADDR_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int SLOT_W  = (NB > 1) ? $clog2(NB) : 1;

   // configuration
   logic [DIM_W-1:0] fw_ff, fh_ff;
   logic [WIN_W-1:0] ww_ff, wh_ff;
   logic             tmax_ff;
   logic             cfg_hit;

   // derived frame values
   logic [DIM_W-1:0] w, h, small_side;
   logic [WIN_W-1:0] big;
   logic             pass;
   logic [HW_W-1:0]  hw, hh;
   logic [TOT_W-1:0] total, lagv, lago;

   // counters
   logic [TOT_W-1:0]  rcv_ff, rcv_in, vm_ff, vm_in, on_ff, on_in, rcv_n;
   logic [DIM_W-1:0]  in_col_ff, in_col_in, v_col_ff, v_col_in, v_row_ff, v_row_in;
   logic [SLOT_W-1:0] in_slot_ff, in_slot_in, v_slot_ff, v_slot_in;

   logic    acc, full_rcv, wr, active, vstep_a, out_a, fe_a;
   tok_type tok_a;
   logic [NB-1:0] vmask;

   // pipeline
   tok_type           b_tok_ff, c_tok_ff, d_tok_ff, e_tok_ff;
   logic              b_byp_ff, b_par_ff, c_par_ff;
   logic [SLOT_W-1:0] b_slot_ff;
   logic [PIX_W-1:0]  b_pix_ff;
   logic [NB-1:0]     b_mask_ff;
   logic [PIX_W-1:0]  ram_q [NB];
   logic [PIX_W-1:0]  c_grp_in [NG];
   logic [PIX_W-1:0]  c_grp_ff [NG];
   logic [PIX_W-1:0]  vval;
   tap_type           tap_d [NT];
   tap_type           tap_q [NT];
   logic              chain_clr, par_ctr, ctr_valid;
   logic [NT-1:0]     hmask;
   logic [PIX_W-1:0]  e_grp_in [NTG];
   logic [PIX_W-1:0]  e_grp_ff [NTG];
   logic [PIX_W-1:0]  oval;

   logic              pop, drop;
   logic [PEND_W-1:0] pend_ff, pend_in;
   out_type           fifo_q;

   // configuration port
   always_comb begin
      case (csr_addr)
         CSR_FRAME_WIDTH, CSR_FRAME_HEIGHT, CSR_WINDOW_WIDTH,
         CSR_WINDOW_HEIGHT, CSR_TAKE_MAX: cfg_hit = csr_we;
         default:                         cfg_hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff   <= DIM_W'(1024);
         fh_ff   <= DIM_W'(1024);
         ww_ff   <= WIN_W'(3);
         wh_ff   <= WIN_W'(3);
         tmax_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_FRAME_WIDTH:   fw_ff   <= csr_wdata;
            CSR_FRAME_HEIGHT:  fh_ff   <= csr_wdata;
            CSR_WINDOW_WIDTH:  ww_ff   <= csr_wdata[WIN_W-1:0];
            CSR_WINDOW_HEIGHT: wh_ff   <= csr_wdata[WIN_W-1:0];
            CSR_TAKE_MAX:      tmax_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      w = fw_ff;
      if (fw_ff == '0) begin
         w = DIM_W'(1);
      end else if (int'(fw_ff) > MAX_WIDTH) begin
         w = DIM_W'(MAX_WIDTH);
      end
      h = fh_ff;
      if (fh_ff == '0) begin
         h = DIM_W'(1);
      end else if (int'(fh_ff) > MAX_HEIGHT) begin
         h = DIM_W'(MAX_HEIGHT);
      end
      big        = (ww_ff > wh_ff) ? ww_ff : wh_ff;
      small_side = (w < h) ? w : h;
      pass = (ww_ff == '0) || (wh_ff == '0) || (DIM_W'(big) >= small_side) ||
             ((ww_ff == WIN_W'(1)) && (wh_ff == WIN_W'(1)));
      hw    = pass ? '0 : half_of(ww_ff, ODD_CAP);
      hh    = pass ? '0 : half_of(wh_ff, ODD_CAP);
      total = TOT_W'(w) * TOT_W'(h);
      lagv  = TOT_W'(hh) * TOT_W'(w);
      lago  = lagv + TOT_W'(hw);
   end

   // transaction decode
   assign acc      = req_tvalid & req_tready;
   assign full_rcv = (rcv_ff == total);
   assign wr       = acc & ~req_tuser & ~full_rcv;
   assign active   = acc & (wr | full_rcv);
   assign rcv_n    = rcv_ff + TOT_W'(wr);
   assign vstep_a  = active & (vm_ff < total) & ((rcv_n == total) | (rcv_n > vm_ff + lagv));
   assign out_a    = active & (on_ff < total) & ((rcv_n == total) | (rcv_n > on_ff + lago));
   assign fe_a     = out_a & (on_ff == total - TOT_W'(1));

   always_comb begin
      tok_a.item  = acc;
      tok_a.step  = vstep_a | out_a;
      tok_a.vstep = vstep_a;
      tok_a.out   = out_a;
      tok_a.fe    = fe_a;
      tok_a.last  = fe_a;
   end

   always_comb begin
      rcv_in     = rcv_n;
      in_col_in  = in_col_ff;
      in_slot_in = in_slot_ff;
      vm_in      = vm_ff;
      v_col_in   = v_col_ff;
      v_row_in   = v_row_ff;
      v_slot_in  = v_slot_ff;
      on_in      = on_ff + TOT_W'(out_a);
      if (wr) begin
         if (in_col_ff == w - DIM_W'(1)) begin
            in_col_in  = '0;
            in_slot_in = (in_slot_ff == SLOT_W'(NB - 1)) ? '0 : in_slot_ff + SLOT_W'(1);
         end else begin
            in_col_in = in_col_ff + DIM_W'(1);
         end
      end
      if (vstep_a) begin
         vm_in = vm_ff + TOT_W'(1);
         if (v_col_ff == w - DIM_W'(1)) begin
            v_col_in  = '0;
            v_row_in  = v_row_ff + DIM_W'(1);
            v_slot_in = (v_slot_ff == SLOT_W'(NB - 1)) ? '0 : v_slot_ff + SLOT_W'(1);
         end else begin
            v_col_in = v_col_ff + DIM_W'(1);
         end
      end
      if (fe_a || cfg_hit) begin
         rcv_in     = '0;
         in_col_in  = '0;
         in_slot_in = '0;
         vm_in      = '0;
         v_col_in   = '0;
         v_row_in   = '0;
         v_slot_in  = '0;
         on_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rcv_ff     <= '0;
         in_col_ff  <= '0;
         in_slot_ff <= '0;
         vm_ff      <= '0;
         v_col_ff   <= '0;
         v_row_ff   <= '0;
         v_slot_ff  <= '0;
         on_ff      <= '0;
      end else begin
         rcv_ff     <= rcv_in;
         in_col_ff  <= in_col_in;
         in_slot_ff <= in_slot_in;
         vm_ff      <= vm_in;
         v_col_ff   <= v_col_in;
         v_row_ff   <= v_row_in;
         v_slot_ff  <= v_slot_in;
         on_ff      <= on_in;
      end
   end

   // rows of the vertical window for the column being reduced
   always_comb begin
      int d;
      for (int k = 0; k < NB; k++) begin
         d = (k >= int'(v_slot_ff)) ? k - int'(v_slot_ff) : k + NB - int'(v_slot_ff);
         vmask[k] = 1'b0;
         if (d == 0) begin
            vmask[k] = 1'b1;
         end else if (d <= int'(hh) && int'(v_row_ff) + d <= int'(h) - 1) begin
            vmask[k] = 1'b1;
         end else if (NB - d <= int'(hh) && int'(v_row_ff) >= NB - d) begin
            vmask[k] = 1'b1;
         end
      end
   end

   // row stores, one per slot
   for (genvar k = 0; k < NB; k++) begin : g_bank
      gred_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram (
         .clock (clock),
         .we    (wr && (in_slot_ff == SLOT_W'(k))),
         .waddr (ADDR_W'(in_col_ff)),
         .wdata (req_tdata),
         .raddr (ADDR_W'(v_col_ff)),
         .rdata (ram_q[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_tok_ff <= '0;
         c_tok_ff <= '0;
         d_tok_ff <= '0;
         e_tok_ff <= '0;
      end else begin
         b_tok_ff <= tok_a;
         c_tok_ff <= b_tok_ff;
         d_tok_ff <= c_tok_ff;
         e_tok_ff <= d_tok_ff;
      end
      b_byp_ff  <= wr;
      b_slot_ff <= in_slot_ff;
      b_pix_ff  <= req_tdata;
      b_mask_ff <= vmask;
      b_par_ff  <= v_row_ff[0];
      c_par_ff  <= b_par_ff;
      c_grp_ff  <= c_grp_in;
      e_grp_ff  <= e_grp_in;
   end

   // vertical reduction, first level (newest row comes straight from the input)
   always_comb begin
      logic [PIX_W-1:0] v;
      for (int g = 0; g < NG; g++) begin
         c_grp_in[g] = red_ident(tmax_ff);
         for (int i = 0; i < 4; i++) begin
            if (4 * g + i < NB) begin
               v = (b_byp_ff && (int'(b_slot_ff) == 4 * g + i)) ? b_pix_ff : ram_q[4 * g + i];
               if (b_mask_ff[4 * g + i]) begin
                  c_grp_in[g] = red2(c_grp_in[g], v, tmax_ff);
               end
            end
         end
      end
   end

   always_comb begin
      vval = red_ident(tmax_ff);
      for (int g = 0; g < NG; g++) begin
         vval = red2(vval, c_grp_ff[g], tmax_ff);
      end
   end

   // horizontal window chain
   assign chain_clr = d_tok_ff.last | cfg_hit;

   for (genvar j = 0; j < NT; j++) begin : g_tap
      if (j == 0) begin : g_head
         assign tap_d[j] = '{valid: c_tok_ff.vstep, par: c_par_ff, val: vval};
      end else begin : g_body
         assign tap_d[j] = tap_q[j-1];
      end
      gred_cell u_cell (
         .clock (clock),
         .reset (reset),
         .shift (c_tok_ff.step),
         .kill  (chain_clr & ~((j == 0) & c_tok_ff.step)),
         .din   (tap_d[j]),
         .q     (tap_q[j])
      );
   end

   always_comb begin
      par_ctr   = 1'b0;
      ctr_valid = 1'b0;
      for (int j = 0; j < NT; j++) begin
         if (j == int'(hw)) begin
            par_ctr   = tap_q[j].par;
            ctr_valid = tap_q[j].valid;
         end
      end
      for (int j = 0; j < NT; j++) begin
         hmask[j] = tap_q[j].valid && (j <= 2 * int'(hw)) && (tap_q[j].par == par_ctr);
      end
      for (int g = 0; g < NTG; g++) begin
         e_grp_in[g] = red_ident(tmax_ff);
         for (int i = 0; i < 4; i++) begin
            if (4 * g + i < NT) begin
               if (hmask[4 * g + i]) begin
                  e_grp_in[g] = red2(e_grp_in[g], tap_q[4 * g + i].val, tmax_ff);
               end
            end
         end
      end
   end

   always_comb begin
      oval = red_ident(tmax_ff);
      for (int g = 0; g < NTG; g++) begin
         oval = red2(oval, e_grp_ff[g], tmax_ff);
      end
   end

   // result queue and credit count
   gred_ofifo #(.DEPTH(FDEPTH)) u_ofifo (
      .clock (clock),
      .reset (reset),
      .push  (e_tok_ff.out),
      .din   ('{fe: e_tok_ff.fe, pix: oval}),
      .pop   (pop),
      .valid (rsp_tvalid),
      .dout  (fifo_q)
   );

   assign pop       = rsp_tvalid & rsp_tready;
   assign drop      = e_tok_ff.item & ~e_tok_ff.out;
   assign pend_in   = pend_ff + PEND_W'(acc) - PEND_W'(drop) - PEND_W'(pop);
   assign req_tready = (pend_ff < PEND_W'(FDEPTH));
   assign rsp_tdata = fifo_q.pix;
   assign rsp_tlast = fifo_q.fe;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= PEND_W'(FDEPTH))
      else $error("transaction credit count overflow");

   a_rsp_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (pend_ff != '0))
      else $error("result offered with no transaction outstanding");

   a_centre_tap: assert property (@(posedge clock) disable iff (reset)
      d_tok_ff.out |-> ctr_valid)
      else $error("window centre tap empty on output");

   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      (acc && fe_a && !cfg_hit) |=> (rcv_ff == '0 && vm_ff == '0 && on_ff == '0))
      else $error("counters not cleared after last pixel of frame");

endmodule

### hw/rtl/gred_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gred_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/gred_cell.sv
// One tap of the horizontal window chain: holds a column result, passes it on.
module gred_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             shift,
   input  logic             kill,
   input  gred_pkg::tap_type din,
   output gred_pkg::tap_type q
);
   import gred_pkg::*;

   logic             valid_ff;
   logic             par_ff;
   logic [PIX_W-1:0] val_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift) begin
         valid_ff <= din.valid & ~kill;
      end else if (kill) begin
         valid_ff <= 1'b0;
      end
      if (shift) begin
         par_ff <= din.par;
         val_ff <= din.val;
      end
   end

   assign q = '{valid: valid_ff, par: par_ff, val: val_ff};

endmodule

### hw/rtl/gred_ofifo.sv
// Result queue between the filter pipeline and the output channel.
module gred_ofifo #(
   parameter int DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  gred_pkg::out_type din,
   input  logic              pop,
   output logic              valid,
   output gred_pkg::out_type dout
);
   import gred_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   out_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff + CNT_W'(push) - CNT_W'(pop);
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= din;
      end
   end

   assign valid = (cnt_ff != '0);
   assign dout  = mem_ff[rd_ff];

endmodule

### tb/sv/tb_gray_rect_erode_dilate_top.sv
// Testbench for the grayscale rectangular erode/dilate filter: a streaming predictor and checker.
module tb_gray_rect_erode_dilate_top;
   import gred_pkg::*;

   localparam int FMAX_W   = 1024;
   localparam int FMAX_H   = 1024;
   localparam int WMAX     = 15;
   localparam int WCAP     = ((WMAX - 1) | 1);
   localparam int LIMIT    = 2000000;
   localparam bit KIND_PIX = 1'b0;
   localparam bit KIND_DRAIN = 1'b1;

   class morph_scoreboard;
      int unsigned frame_w, frame_h, win_w, win_h;
      bit          use_max;
      int unsigned col, row, out_idx, half_w, half_h;
      byte unsigned rows[WMAX * FMAX_W];
      out_type     awaited[$];
      int          errors;

      function new();
         frame_w = 1024; frame_h = 1024; win_w = 3; win_h = 3; use_max = 0;
         col = 0; row = 0; out_idx = 0; half_w = 0; half_h = 0; errors = 0;
         foreach (rows[i]) rows[i] = 0;
      endfunction

      function int unsigned clip(int unsigned v, int unsigned top);
         return (v < 1) ? 1 : ((v > top) ? top : v);
      endfunction

      function int unsigned half(int unsigned v);
         int unsigned odd;
         odd = v | 1;
         if (odd > WCAP) odd = WCAP;
         return odd / 2;
      endfunction

      function void write_reg(csr_idx_type idx, int unsigned val);
         case (idx)
            CSR_FRAME_WIDTH:   frame_w = val & 'h7FF;
            CSR_FRAME_HEIGHT:  frame_h = val & 'h7FF;
            CSR_WINDOW_WIDTH:  win_w = val & 'hF;
            CSR_WINDOW_HEIGHT: win_h = val & 'hF;
            CSR_TAKE_MAX:      use_max = val[0];
            default: ;
         endcase
         col = 0; row = 0; out_idx = 0;
      endfunction

      // refreshes the half sizes and returns the output lag in items
      function int unsigned lag();
         int unsigned w, h, big;
         bit thru;
         w = clip(frame_w, FMAX_W);
         h = clip(frame_h, FMAX_H);
         big = (win_w > win_h) ? win_w : win_h;
         thru = (win_w == 0) || (win_h == 0) || (big >= ((w < h) ? w : h)) ||
                (win_w == 1 && win_h == 1);
         half_w = thru ? 0 : half(win_w);
         half_h = thru ? 0 : half(win_h);
         return half_h * w + half_w;
      endfunction

      function byte unsigned reduce(int unsigned r, int unsigned c, int unsigned w,
                                    int unsigned h);
         int unsigned r0, r1, c0, c1;
         byte unsigned acc, v;
         r0 = (r > half_h) ? r - half_h : 0;
         r1 = (r + half_h < h) ? r + half_h : h - 1;
         c0 = (c > half_w) ? c - half_w : 0;
         c1 = (c + half_w < w) ? c + half_w : w - 1;
         acc = use_max ? 8'd0 : 8'd255;
         for (int unsigned y = r0; y <= r1; y++)
            for (int unsigned x = c0; x <= c1; x++) begin
               v = rows[(y % WMAX) * FMAX_W + x];
               if (use_max ? (v > acc) : (v < acc)) acc = v;
            end
         return acc;
      endfunction

      function void note_input(bit kind, byte unsigned pix);
         int unsigned w, h, total, got, lg;
         out_type o;
         lg = lag();
         w = clip(frame_w, FMAX_W);
         h = clip(frame_h, FMAX_H);
         total = w * h;
         if (col >= w || row > h) begin col = 0; row = 0; out_idx = 0; end
         got = row * w + col;
         if (got > total) begin col = 0; row = 0; out_idx = 0; got = 0; end
         if (kind == KIND_PIX && got < total) begin
            rows[(row % WMAX) * FMAX_W + col] = pix;
            col++;
            if (col >= w) begin col = 0; row++; end
            got++;
         end else if (got < total) return;
         if (out_idx >= total) begin col = 0; row = 0; out_idx = 0; return; end
         if (got < total && got - 1 < out_idx + lg) return;
         o.pix = reduce(out_idx / w, out_idx % w, w, h);
         o.fe = (out_idx == total - 1);
         awaited.push_back(o);
         out_idx++;
         if (out_idx >= total) begin col = 0; row = 0; out_idx = 0; end
      endfunction

      function void check_result(logic [PIX_W-1:0] pix, logic fe);
         out_type e;
         if (awaited.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result pix=%0d last=%0b", pix, fe);
            return;
         end
         e = awaited.pop_front();
         if (e.pix !== pix || e.fe !== fe) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: exp pix=%0d last=%0b, got pix=%0d last=%0b",
                        e.pix, e.fe, pix, fe);
         end
      endfunction
   endclass

   logic clock = 1'b0, reset = 1'b1;
   logic req_tvalid = 1'b0, req_tuser = 1'b0, rsp_tready = 1'b0, csr_we = 1'b0;
   logic [PIX_W-1:0] req_tdata = '0;
   logic [CSR_A_W-1:0] csr_addr = '0;
   logic [CFG_W-1:0] csr_wdata = '0;
   logic req_tready, rsp_tvalid, rsp_tlast;
   logic [PIX_W-1:0] rsp_tdata;

   morph_scoreboard sb = new();
   bit send_idle, recv_stall;
   int idle_pct = 48;
   int hold_left, hold_cycles, hold_tag, hold_seen;
   int cycles, rand_items, phase;

   gray_rect_erode_dilate_top dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      if (hold_tag != hold_seen) begin
         hold_seen = hold_tag;
         hold_left = hold_cycles;
      end
      if (hold_left > 0) begin
         rsp_tready = 1'b0;
         hold_left--;
      end else
         rsp_tready = !(recv_stall && $urandom_range(99) < idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tlast);
      cycles++;
      if (cycles > LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic push(bit kind, byte unsigned pix);
      while (send_idle && $urandom_range(99) < idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = kind;
      req_tdata = pix;
      do @(posedge clock); while (!req_tready);
      sb.note_input(kind, pix);
      @(negedge clock);
   endtask

   task automatic settle();
      req_tvalid = 1'b0;
      while (sb.awaited.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_csr(csr_idx_type idx, int unsigned val);
      req_tvalid = 1'b0;
      csr_we = 1'b1;
      csr_addr = idx;
      csr_wdata = CFG_W'(val);
      @(posedge clock);
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   function automatic byte unsigned any_pixel();
      if ($urandom_range(99) < 10) return $urandom_range(1) ? 8'd255 : 8'd0;
      return 8'($urandom_range(255));
   endfunction

   // one frame: npix < 0 means the whole frame; noise puts drains and stray pixels around
   task automatic run_frame(int unsigned fw, fh, ww, wh, bit tmax, int npix, bit noise,
                            int hold = 0);
      int unsigned total, n, extra;
      send_idle = (phase % 4 == 1) || (phase % 4 == 3);
      recv_stall = (phase % 4 == 2) || (phase % 4 == 3);
      idle_pct = (phase % 4 == 3) ? 20 : 48;
      phase++;
      write_csr(CSR_FRAME_WIDTH, fw);
      write_csr(CSR_FRAME_HEIGHT, fh);
      write_csr(CSR_WINDOW_WIDTH, ww);
      write_csr(CSR_WINDOW_HEIGHT, wh);
      write_csr(CSR_TAKE_MAX, tmax);
      total = sb.clip(fw & 'h7FF, FMAX_W) * sb.clip(fh & 'h7FF, FMAX_H);
      n = (npix < 0) ? total : npix;
      if (hold > 0) begin
         hold_cycles = hold;
         hold_tag++;
      end
      for (int unsigned i = 0; i < n; i++) begin
         if (noise && $urandom_range(99) < 6) push(KIND_DRAIN, 8'($urandom_range(255)));
         push(KIND_PIX, any_pixel());
      end
      if (n == total) begin
         extra = sb.lag() + (noise ? $urandom_range(0, 3) : 0);
         for (int unsigned i = 0; i < extra; i++)
            push((noise && $urandom_range(99) < 25) ? KIND_PIX : KIND_DRAIN, any_pixel());
      end
      rand_items += n;
      settle();
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset = 1'b0;
      run_frame(4, 3, 0, 3, 0, -1, 0);
      run_frame(5, 4, 1, 1, 1, -1, 0);
      run_frame(3, 5, 3, 2, 0, -1, 1);
      run_frame(0, 6, 3, 3, 1, -1, 1);
      run_frame(6, 5, 3, 2, 1, -1, 1);
      run_frame(8, 7, 5, 4, 0, 20, 1);
      run_frame(20, 18, 15, 15, 1, -1, 1, 400);
      run_frame(16, 16, 14, 0, 0, -1, 0);
      run_frame(2047, 4, 3, 1, 1, 60, 1);
      run_frame(1, 2047, 0, 0, 0, 60, 0);
      run_frame(1024, 1024, 15, 15, 1, 0, 1);
      while (rand_items < 1200) begin
         if ($urandom_range(99) < 10)
            run_frame($urandom_range(1, 24), $urandom_range(1, 24), $urandom_range(15),
                      $urandom_range(15), 1'($urandom_range(1)), $urandom_range(0, 30), 1);
         else
            run_frame($urandom_range(1, 24), $urandom_range(1, 24), $urandom_range(15),
                      $urandom_range(15), 1'($urandom_range(1)), -1,
                      $urandom_range(99) < 30);
      end
      settle();
      if (sb.errors == 0 && sb.awaited.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule
